### hdl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; every other file in hdl/ refers to this package.
package sfr_pkg;

   localparam int RES_MAX     = 8;  // most results one item can cause
   localparam int CNT_W       = 4;  // holds counts 0..8
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_BYTES      = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LENGTH     = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPLACEMENT_BYTES  = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPLACEMENT_LENGTH = 8'd3;

   typedef logic [7:0]       byte_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [63:0] pattern;
      cnt_type     plen;
      logic [63:0] repl;
      cnt_type     rlen;
      logic        clear;   // pattern length written: drop pending bytes
   } cfg_type;

   // one job: the full result list caused by one input item
   typedef struct packed {
      logic [RES_MAX-1:0][7:0] bytes;
      cnt_type                 count;
      logic                    last;
   } job_type;

endpackage

### hdl/sfr_if.sv
// Valid/ready channel interfaces: input items, results and register writes.
// Depends on sfr_pkg.
interface sfr_req_if;
   logic               valid;
   logic               ready;
   sfr_pkg::byte_type  data_byte;
   logic               has_byte;
   logic               end_of_string;
   modport source (output valid, data_byte, has_byte, end_of_string, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_string, output ready);
endinterface

interface sfr_rsp_if;
   logic               valid;
   logic               ready;
   sfr_pkg::byte_type  out_byte;
   logic               out_valid;
   logic               out_last;
   modport source (output valid, out_byte, out_valid, out_last, input ready);
   modport sink   (input valid, out_byte, out_valid, out_last, output ready);
endinterface

interface sfr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sfr_pkg::CSR_ADDR_W-1:0]     addr;
   logic [sfr_pkg::CSR_DATA_W-1:0]     wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### hdl/sfr_front.sv
// Front end: accepts input bytes, keeps the pending window, matches the
// pattern and turns each item that causes results or ends a string into one job. Depends on sfr_pkg, sfr_if.
module sfr_front #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic             clock,
   input  logic             reset,
   sfr_req_if.sink          req_ch,
   input  sfr_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             push,
   output sfr_pkg::job_type job
);

   localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam sfr_pkg::cnt_type MaxPat = sfr_pkg::CNT_W'(MAX_PATTERN);
   localparam sfr_pkg::cnt_type MaxRep = sfr_pkg::CNT_W'(MAX_REPLACEMENT);

   sfr_pkg::byte_type win_ff [MAX_PATTERN];
   sfr_pkg::byte_type win_in [MAX_PATTERN];
   sfr_pkg::byte_type win1   [MAX_PATTERN];
   sfr_pkg::cnt_type  count_ff, count_in;
   sfr_pkg::cnt_type  plen, rlen, cnt0, cnt1, cnt2;
   logic              full, match, accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept && (job.count != '0 || req_ch.end_of_string);

   always_comb begin
      if (cfg.plen == '0) begin
         plen = sfr_pkg::CNT_W'(1);
      end else if (cfg.plen > MaxPat) begin
         plen = MaxPat;
      end else begin
         plen = cfg.plen;
      end
      rlen = (cfg.rlen > MaxRep) ? MaxRep : cfg.rlen;
   end

   always_comb begin
      cnt0 = (count_ff >= plen) ? '0 : count_ff;
      win1 = win_ff;
      if (req_ch.has_byte) begin
         win1[cnt0[IdxW-1:0]] = req_ch.data_byte;
      end
      cnt1  = cnt0 + sfr_pkg::CNT_W'(req_ch.has_byte);
      full  = req_ch.has_byte && (cnt1 == plen);
      match = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (sfr_pkg::CNT_W'(i) < plen && win1[i] != cfg.pattern[8*i +: 8]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      job.bytes = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         job.bytes[i] = win1[i];
      end
      job.last = req_ch.end_of_string;
      win_in   = win1;
      priority if (full && match) begin
         job.bytes = cfg.repl;
         job.count = rlen;
         cnt2      = '0;
      end else if (full) begin
         // oldest byte goes out (all pending bytes at end of string), window shifts by one
         job.count = req_ch.end_of_string ? plen : sfr_pkg::CNT_W'(1);
         cnt2      = plen - sfr_pkg::CNT_W'(1);
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            win_in[i] = win1[i+1];
         end
      end else begin
         job.count = req_ch.end_of_string ? cnt1 : '0;
         cnt2      = cnt1;
      end
      count_in = req_ch.end_of_string ? '0 : cnt2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cfg.clear) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

### hdl/sfr_queue.sv
// Two-entry job queue between the front end and the result sequencer.
// Depends on sfr_pkg.
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::job_type push_job,
   input  logic             pop,
   output sfr_pkg::job_type head,
   output logic             empty,
   output logic             full
);

   localparam int PtrW  = $clog2(sfr_pkg::QUEUE_DEPTH);
   localparam int FillW = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

   sfr_pkg::job_type  mem_ff [sfr_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FillW-1:0]  fill_ff, fill_in;

   assign head  = mem_ff[rd_ff];
   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == FillW'(sfr_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_in   = push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in   = pop  ? rd_ff + PtrW'(1) : rd_ff;
      fill_in = fill_ff + FillW'(push) - FillW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

### hdl/sfr_back.sv
// Result sequencer: walks the head job one result per cycle, while the receiver is ready, into the
// registered result channel. Depends on sfr_pkg, sfr_if.
module sfr_back (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::job_type head,
   input  logic             head_valid,
   output logic             pop,
   sfr_rsp_if.source        rsp_ch
);

   localparam int IdxW = $clog2(sfr_pkg::RES_MAX);

   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              vld_ff, vld_in;
   sfr_pkg::byte_type byte_ff, byte_in;
   logic              bval_ff, bval_in;
   logic              last_ff, last_in;
   logic              load, final_res;

   assign rsp_ch.valid     = vld_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.out_valid = bval_ff;
   assign rsp_ch.out_last  = last_ff;

   assign load      = head_valid && (!vld_ff || rsp_ch.ready);
   assign final_res = (head.count == '0)
                   || (sfr_pkg::CNT_W'(idx_ff) == head.count - sfr_pkg::CNT_W'(1));
   assign pop       = load && final_res;

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff && !rsp_ch.ready;
      byte_in = byte_ff;
      bval_in = bval_ff;
      last_in = last_ff;
      if (load) begin
         vld_in = 1'b1;
         if (head.count == '0) begin
            // bare end marker
            byte_in = '0;
            bval_in = 1'b0;
         end else begin
            byte_in = head.bytes[idx_ff];
            bval_in = 1'b1;
         end
         last_in = head.last && final_res;
         idx_in  = final_res ? '0 : idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      last_ff <= last_in;
   end

endmodule

### hdl/stream_find_replace.sv
// Stream find-and-replace: each input job is registered in the two-entry job queue, and
// its results in the result sequencer. Throughput one input and one result transfer per
// cycle, unless the receiver stalls or multi-result items fill the queue and stall input.
// Synchronous active-high reset clears the window count, queue and output valid;
// registers reset to pattern length 1, everything else zero.
// Depends on sfr_pkg, sfr_if, sfr_front, sfr_queue, sfr_back.
module stream_find_replace #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_ch,
   sfr_rsp_if.source rsp_ch,
   sfr_csr_if.sink   csr_ch
);

   sfr_pkg::cfg_type cfg;
   logic [63:0]      pattern_ff, repl_ff;
   sfr_pkg::cnt_type plen_ff, rlen_ff;
   logic             csr_wr;
   logic             q_push, q_pop, q_empty, q_full;
   sfr_pkg::job_type push_job, head_job;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= sfr_pkg::CNT_W'(1);
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_ch.addr)
            sfr_pkg::CSR_PATTERN_BYTES:      pattern_ff <= csr_ch.wdata;
            sfr_pkg::CSR_PATTERN_LENGTH:     plen_ff    <= csr_ch.wdata[sfr_pkg::CNT_W-1:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  repl_ff    <= csr_ch.wdata;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: rlen_ff    <= csr_ch.wdata[sfr_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern = pattern_ff;
      cfg.plen    = plen_ff;
      cfg.repl    = repl_ff;
      cfg.rlen    = rlen_ff;
      cfg.clear   = csr_wr && (csr_ch.addr == sfr_pkg::CSR_PATTERN_LENGTH);
   end

   sfr_front #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg),
      .q_full (q_full),
      .push   (q_push),
      .job    (push_job)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .head_valid (!q_empty),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("job queue underflow");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_valid) |-> rsp_ch.out_last)
      else $error("end marker without last flag");

   a_pop_after_push: assert property (@(posedge clock) disable iff (reset)
      ($past(q_empty) && !$past(q_push) && !$past(reset)) |-> !q_pop)
      else $error("pop of a job never pushed");

endmodule

### tb/find_replace_checker.sv
`timescale 1ns / 100ps
// Result checker for stream_find_replace: follows register writes and input transfers,
// predicts the rewritten byte stream and compares every result transfer against it.
// Depends on sfr_pkg and the channel interfaces of sfr_if.
module find_replace_checker (
   input  logic clock,
   input  logic reset,
   sfr_req_if   req,
   sfr_rsp_if   rsp,
   sfr_csr_if   csr,
   output int   fail_count,
   output int   pending_results
);
   import sfr_pkg::*;

   typedef struct packed {
      byte_type data;
      logic     valid;
      logic     last;
   } out_item_type;

   out_item_type rewritten_q[$];
   logic [63:0]  pattern_r;
   logic [63:0]  repl_r;
   cnt_type      plen_r;
   cnt_type      rlen_r;
   byte_type     window [0:7];
   int unsigned  window_cnt;

   task automatic rewrite_item(input byte_type data, input logic has, input logic eos);
      out_item_type batch [0:15];
      int unsigned  n;
      int unsigned  i;
      int unsigned  plen;
      int unsigned  rlen;
      logic         hit;
      n = 0;
      plen = (plen_r == 0) ? 1 : ((plen_r > 8) ? 8 : plen_r);
      rlen = (rlen_r > 8) ? 8 : rlen_r;
      if (window_cnt >= plen) window_cnt = 0;
      if (has) begin
         window[window_cnt] = data;
         window_cnt++;
         if (window_cnt == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
               if (window[i] != pattern_r[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (i = 0; i < rlen; i++) begin
                  batch[n] = '{repl_r[8*i +: 8], 1'b1, 1'b0};
                  n++;
               end
               window_cnt = 0;
            end else begin
               batch[n] = '{window[0], 1'b1, 1'b0};
               n++;
               for (i = 1; i < plen; i++) window[i-1] = window[i];
               window_cnt--;
            end
         end
      end
      if (eos) begin
         for (i = 0; i < window_cnt; i++) begin
            batch[n] = '{window[i], 1'b1, 1'b0};
            n++;
         end
         window_cnt = 0;
         // nothing to flush: bare end marker
         if (n == 0) begin
            batch[0] = '{8'h00, 1'b0, 1'b0};
            n = 1;
         end
         batch[n-1].last = 1'b1;
      end
      for (i = 0; i < n; i++) rewritten_q.push_back(batch[i]);
   endtask

   always @(posedge clock) begin : watch
      out_item_type want;
      if (reset) begin
         pattern_r  = '0;
         plen_r     = 4'd1;
         repl_r     = '0;
         rlen_r     = '0;
         window_cnt = 0;
         fail_count = 0;
         rewritten_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            unique case (csr.addr)
               CSR_PATTERN_BYTES:      pattern_r = csr.wdata;
               CSR_PATTERN_LENGTH: begin
                  plen_r     = csr.wdata[3:0];
                  window_cnt = 0;
               end
               CSR_REPLACEMENT_BYTES:  repl_r = csr.wdata;
               CSR_REPLACEMENT_LENGTH: rlen_r = csr.wdata[3:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            rewrite_item(req.data_byte, req.has_byte, req.end_of_string);
         if (rsp.valid && rsp.ready) begin
            if (rewritten_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got byte %h valid %b last %b",
                        $time, rsp.out_byte, rsp.out_valid, rsp.out_last);
               fail_count++;
            end else begin
               want = rewritten_q.pop_front();
               if (rsp.out_byte !== want.data || rsp.out_valid !== want.valid ||
                   rsp.out_last !== want.last) begin
                  $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                           $time, want.data, want.valid, want.last,
                           rsp.out_byte, rsp.out_valid, rsp.out_last);
                  fail_count++;
               end
            end
         end
      end
      pending_results <= rewritten_q.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the stream_find_replace testbench: clock, reset, register setup, byte-string
// stimulus with sender gaps and receiver stalls, and the final verdict.
// Depends on sfr_pkg, sfr_if, stream_find_replace and find_replace_checker.
module testbench;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   int          send_idle_pct;
   int          stall_pct;
   int unsigned items_sent;
   logic [63:0] cur_pattern;
   int unsigned cur_plen;
   int          cycles = 0;
   int          fails;
   int          outstanding;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();
   sfr_csr_if csr_bus ();

   stream_find_replace dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   find_replace_checker rewrite_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_bus),
      .rsp             (rsp_bus),
      .csr             (csr_bus),
      .fail_count      (fails),
      .pending_results (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_item(input byte_type data, input logic has, input logic eos);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= data;
      req_bus.has_byte      <= has;
      req_bus.end_of_string <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (has || eos) items_sent++;
   endtask

   // stop sending and let every expected result arrive
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata, input logic hold);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.wdata <= wdata;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (!hold) csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [63:0] pat, input logic [63:0] plen_w,
                             input logic [63:0] repl, input logic [63:0] rlen_w);
      csr_write(CSR_PATTERN_BYTES, pat, 1'b1);
      csr_write(CSR_PATTERN_LENGTH, plen_w, 1'b1);
      csr_write(CSR_REPLACEMENT_BYTES, repl, 1'b1);
      csr_write(CSR_REPLACEMENT_LENGTH, rlen_w, 1'b0);
      cur_pattern = pat;
      cur_plen = (plen_w[3:0] == 0) ? 1 : ((plen_w[3:0] > 8) ? 8 : plen_w[3:0]);
   endtask

   task automatic random_config();
      logic [63:0] pat;
      logic [63:0] plen_w;
      logic [63:0] rlen_w;
      int unsigned k;
      int unsigned pl;
      case ($urandom_range(9))
         0:       pl = 0;
         1:       pl = $urandom_range(9, 15);
         2:       pl = 8;
         default: pl = $urandom_range(1, 4);
      endcase
      for (k = 0; k < 8; k++)
         pat[8*k +: 8] = ($urandom_range(3) == 0) ? byte_type'($urandom_range(255))
                                                  : byte_type'(8'h61 + $urandom_range(2));
      plen_w = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
      plen_w[3:0] = 4'(pl);
      rlen_w = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
      rlen_w[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(8));
      if ($urandom_range(5) == 0)
         csr_write(CSR_ADDR_W'(4 + $urandom_range(251)), {$urandom, $urandom}, 1'b1);
      set_config(pat, plen_w, {$urandom, $urandom}, rlen_w);
   endtask

   // mostly pattern copies, broken prefixes and pattern-like bytes, some noise
   task automatic send_string(input int unsigned len);
      byte_type    text[$];
      int unsigned k;
      int unsigned j;
      logic        bare_end;
      while (text.size() < len) begin
         case ($urandom_range(7))
            0, 1, 2: for (k = 0; k < cur_plen; k++) text.push_back(cur_pattern[8*k +: 8]);
            3: begin
               j = $urandom_range(cur_plen - 1);
               for (k = 0; k < j; k++) text.push_back(cur_pattern[8*k +: 8]);
               text.push_back(byte_type'(8'h61 + $urandom_range(2)));
            end
            4:       text.push_back(byte_type'($urandom_range(255)));
            5:       text.push_back(cur_pattern[8*$urandom_range(cur_plen - 1) +: 8]);
            default: text.push_back(byte_type'(8'h61 + $urandom_range(2)));
         endcase
      end
      bare_end = ($urandom_range(3) == 0);
      for (k = 0; k < text.size(); k++) begin
         if ($urandom_range(15) == 0) send_item(byte_type'($urandom_range(255)), 1'b0, 1'b0);
         send_item(text[k], 1'b1, !bare_end && (k == text.size() - 1));
      end
      if (bare_end) send_item(byte_type'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic run_phase(input int send_pct, input int stall, input int unsigned quota);
      int unsigned stop_at;
      send_idle_pct = send_pct;
      stall_pct     = stall;
      stop_at       = items_sent + quota;
      random_config();
      while (items_sent < stop_at) begin
         if ($urandom_range(3) == 0) begin
            drain();
            random_config();
         end
         send_string($urandom_range(1, 12));
      end
      drain();
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = 8'h00;
      req_bus.has_byte      = 1'b0;
      req_bus.end_of_string = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.addr          = '0;
      csr_bus.wdata         = '0;
      rsp_bus.ready         = 1'b0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      items_sent            = 0;
      cur_pattern           = '0;
      cur_plen              = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero byte deleted, other byte passed with last, no-op item, bare end marker
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      drain();

      csr_write(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      set_config(64'h0000_0000_0043_4241, 64'd3, 64'h8899_AABB_CCDD_EEFF, 64'd8);
      send_item(8'h78, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'h43, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b1);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);

      // pattern length rewritten with bytes pending: they are dropped
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      drain();
      csr_write(CSR_PATTERN_LENGTH, 64'd2, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      drain();

      // oversized lengths saturate to eight bytes
      set_config(64'h0011_2233_4455_6677, 64'd15, 64'h0123_4567_89AB_CDEF, 64'd15);
      send_item(8'h77, 1'b1, 1'b0);
      send_item(8'h66, 1'b1, 1'b0);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'h44, 1'b1, 1'b0);
      send_item(8'h33, 1'b1, 1'b0);
      send_item(8'h22, 1'b1, 1'b0);
      send_item(8'h11, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      drain();

      // pattern length zero acts as one
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd0);
      send_item(8'hFF, 1'b1, 1'b1);
      drain();

      run_phase(0, 0, 32);
      run_phase(66, 0, 32);
      run_phase(0, 66, 32);
      run_phase(19, 19, 32);

      if (fails == 0 && outstanding == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

### files.f
hdl/sfr_pkg.sv
hdl/sfr_if.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/stream_find_replace.sv
tb/find_replace_checker.sv
tb/testbench.sv
